// ----- src/gfp_pkg.sv -----
// Shared types, constants and helper functions for the position sentence parser.
`timescale 1ns / 1ps

package gfp_pkg;

  // Default values for the top-level parameters.
  localparam int FRACTION_DIGITS_DEF = 5;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // Field widths of the parse state.
  localparam int WHOLE_W = 17;
  localparam int LEN_W   = 3;
  localparam int DEG_W   = 11;
  localparam int MAG_W   = 31;

  localparam logic [WHOLE_W-1:0] WHOLE_MAX = 17'd131071;
  localparam logic [MAG_W-1:0]   LAT_LIMIT = 31'd900000000;
  localparam logic [MAG_W-1:0]   LON_LIMIT = 31'd1800000000;

  // Reciprocal of 100 for the degree split: floor(x / 100) = (x * DEG_RECIP) >> 24.
  localparam int              DEG_RECIP_W = 18;
  localparam logic [17:0]     DEG_RECIP   = 18'd167773;
  localparam int              DEG_SHIFT   = 24;
  // Reciprocal of 15 for the minute scaling: floor(y / 15) = (y * MIN_RECIP) >> 32.
  localparam int              MIN_RECIP_W = 29;
  localparam logic [28:0]     MIN_RECIP   = 29'd286331154;
  localparam int              MIN_SHIFT   = 32;

  // Characters of interest.
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Field numbers, counted in commas seen.
  localparam logic [7:0] FIELD_LAT  = 8'd1;
  localparam logic [7:0] FIELD_LON  = 8'd2;
  localparam logic [7:0] FIELD_SATS = 8'd6;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REQUIRED_COMMAS = 2'd0,
    REG_MIN_SATELLITES  = 2'd1,
    REG_NEGATE          = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_COMMAS = 2'd1,
    STATUS_FEW_SATS   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] required_commas;
    logic [7:0] min_satellites;
    logic       negate;
  } cfg_t;

  // Per-sentence control carried alongside the coordinates.
  typedef struct packed {
    status_t    status;
    logic [7:0] satellites;
    logic       negate;
  } frame_info_t;

  // Power of ten, evaluated at elaboration.
  function automatic longint pow10(input int n);
    longint v;
    v = 1;
    for (int i = 0; i < n; i++) begin
      v = v * 10;
    end
    return v;
  endfunction

  // Bits needed for a fraction of fd decimal digits.
  function automatic int frac_width(input int fd);
    return $clog2(pow10(fd));
  endfunction

  // Constant table of 10^i for i in 0..7, 24 bits wide.
  function automatic logic [23:0] pow10_tab(input logic [2:0] idx);
    logic [23:0] v;
    case (idx)
      3'd0:    v = 24'd1;
      3'd1:    v = 24'd10;
      3'd2:    v = 24'd100;
      3'd3:    v = 24'd1000;
      3'd4:    v = 24'd10000;
      3'd5:    v = 24'd100000;
      3'd6:    v = 24'd1000000;
      3'd7:    v = 24'd10000000;
      default: v = 24'd1;
    endcase
    return v;
  endfunction

endpackage

// ----- src/gfp_front.sv -----
// Front end: takes sentence bytes, counts commas and collects the three fields.
`timescale 1ns / 1ps

module gfp_front #(
  parameter int  FRACTION_DIGITS = gfp_pkg::FRACTION_DIGITS_DEF,
  localparam int FRAC_W = gfp_pkg::frac_width(FRACTION_DIGITS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte_in,
  input  logic                         in_frame_end,
  input  gfp_pkg::cfg_t                cfg,
  input  logic                         push_ready,
  output logic                         push_valid,
  output gfp_pkg::frame_info_t         push_info,
  output logic [gfp_pkg::WHOLE_W-1:0]  push_lat_whole,
  output logic [FRAC_W-1:0]            push_lat_frac,
  output logic [gfp_pkg::LEN_W-1:0]    push_lat_len,
  output logic [gfp_pkg::WHOLE_W-1:0]  push_lon_whole,
  output logic [FRAC_W-1:0]            push_lon_frac,
  output logic [gfp_pkg::LEN_W-1:0]    push_lon_len
);
  import gfp_pkg::*;

  localparam logic [LEN_W-1:0] FracLimit = LEN_W'(FRACTION_DIGITS);

  logic [7:0]         comma_r, comma_nxt;
  logic [WHOLE_W-1:0] lat_whole_r, lat_whole_nxt, lon_whole_r, lon_whole_nxt;
  logic [FRAC_W-1:0]  lat_frac_r, lat_frac_nxt, lon_frac_r, lon_frac_nxt;
  logic [LEN_W-1:0]   lat_len_r, lat_len_nxt, lon_len_r, lon_len_nxt;
  logic [7:0]         sat_r, sat_nxt;
  logic               point_r, point_nxt;

  logic               accept;
  logic               is_comma, is_point, is_digit;
  logic [3:0]         digit;
  logic [WHOLE_W+3:0] lat_whole_x10, lon_whole_x10;
  logic [FRAC_W+3:0]  lat_frac_x10, lon_frac_x10;
  logic [11:0]        sat_x10;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Character classes.
  assign is_comma = (in_byte_in == CHAR_COMMA);
  assign is_point = (in_byte_in == CHAR_POINT);
  assign is_digit = (in_byte_in >= CHAR_ZERO) && (in_byte_in <= CHAR_NINE);
  assign digit    = 4'(in_byte_in - CHAR_ZERO);

  // Decimal accumulation: value * 10 + digit.
  assign lat_whole_x10 = ({4'd0, lat_whole_r} << 3) + ({4'd0, lat_whole_r} << 1)
                       + {{WHOLE_W{1'b0}}, digit};
  assign lon_whole_x10 = ({4'd0, lon_whole_r} << 3) + ({4'd0, lon_whole_r} << 1)
                       + {{WHOLE_W{1'b0}}, digit};
  assign lat_frac_x10  = ({4'd0, lat_frac_r} << 3) + ({4'd0, lat_frac_r} << 1)
                       + {{FRAC_W{1'b0}}, digit};
  assign lon_frac_x10  = ({4'd0, lon_frac_r} << 3) + ({4'd0, lon_frac_r} << 1)
                       + {{FRAC_W{1'b0}}, digit};
  assign sat_x10       = ({4'd0, sat_r} << 3) + ({4'd0, sat_r} << 1) + {8'd0, digit};

  // Parse state update for the current byte.
  always_comb begin
    comma_nxt     = comma_r;
    point_nxt     = point_r;
    lat_whole_nxt = lat_whole_r;
    lat_frac_nxt  = lat_frac_r;
    lat_len_nxt   = lat_len_r;
    lon_whole_nxt = lon_whole_r;
    lon_frac_nxt  = lon_frac_r;
    lon_len_nxt   = lon_len_r;
    sat_nxt       = sat_r;
    if (is_comma) begin
      if (comma_r != 8'hFF) begin
        comma_nxt = comma_r + 8'd1;
      end
      point_nxt = 1'b0;
    end else if (is_point) begin
      if (comma_r == FIELD_LAT || comma_r == FIELD_LON) begin
        point_nxt = 1'b1;
      end
    end else if (is_digit) begin
      if (comma_r == FIELD_LAT) begin
        if (!point_r) begin
          lat_whole_nxt = (lat_whole_x10 > {4'd0, WHOLE_MAX}) ? WHOLE_MAX
                                                             : lat_whole_x10[WHOLE_W-1:0];
        end else if (lat_len_r < FracLimit) begin
          lat_frac_nxt = lat_frac_x10[FRAC_W-1:0];
          lat_len_nxt  = lat_len_r + LEN_W'(1);
        end
      end else if (comma_r == FIELD_LON) begin
        if (!point_r) begin
          lon_whole_nxt = (lon_whole_x10 > {4'd0, WHOLE_MAX}) ? WHOLE_MAX
                                                             : lon_whole_x10[WHOLE_W-1:0];
        end else if (lon_len_r < FracLimit) begin
          lon_frac_nxt = lon_frac_x10[FRAC_W-1:0];
          lon_len_nxt  = lon_len_r + LEN_W'(1);
        end
      end else if (comma_r == FIELD_SATS) begin
        sat_nxt = (sat_x10 > 12'd255) ? 8'hFF : sat_x10[7:0];
      end
    end
  end

  // Sentence record handed to the queue on the last byte.
  always_comb begin
    push_valid            = accept && in_frame_end;
    push_info.satellites  = sat_nxt;
    push_info.negate      = cfg.negate;
    if (comma_nxt != cfg.required_commas) begin
      push_info.status = STATUS_BAD_COMMAS;
    end else if (sat_nxt < cfg.min_satellites) begin
      push_info.status = STATUS_FEW_SATS;
    end else begin
      push_info.status = STATUS_OK;
    end
    push_lat_whole = lat_whole_nxt;
    push_lat_frac  = lat_frac_nxt;
    push_lat_len   = lat_len_nxt;
    push_lon_whole = lon_whole_nxt;
    push_lon_frac  = lon_frac_nxt;
    push_lon_len   = lon_len_nxt;
  end

  // Parse state registers; cleared after every last byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_frame_end)) begin
      comma_r     <= '0;
      point_r     <= 1'b0;
      lat_whole_r <= '0;
      lat_frac_r  <= '0;
      lat_len_r   <= '0;
      lon_whole_r <= '0;
      lon_frac_r  <= '0;
      lon_len_r   <= '0;
      sat_r       <= '0;
    end else if (accept) begin
      comma_r     <= comma_nxt;
      point_r     <= point_nxt;
      lat_whole_r <= lat_whole_nxt;
      lat_frac_r  <= lat_frac_nxt;
      lat_len_r   <= lat_len_nxt;
      lon_whole_r <= lon_whole_nxt;
      lon_frac_r  <= lon_frac_nxt;
      lon_len_r   <= lon_len_nxt;
      sat_r       <= sat_nxt;
    end
  end

endmodule

// ----- src/gfp_fifo.sv -----
// Short first-in first-out queue between the parser front end and the converter.
`timescale 1ns / 1ps

module gfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  import gfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (count_r != (PTR_W+1)'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and occupancy update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (PTR_W+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/gfp_conv.sv -----
// Five-stage pipeline turning ddmm.mmmm into a clamped magnitude in 1e-7 degrees.
`timescale 1ns / 1ps

module gfp_conv #(
  parameter int                        FRACTION_DIGITS = gfp_pkg::FRACTION_DIGITS_DEF,
  parameter logic [gfp_pkg::MAG_W-1:0] LIMIT           = gfp_pkg::LAT_LIMIT,
  localparam int FRAC_W = gfp_pkg::frac_width(FRACTION_DIGITS)
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gfp_pkg::WHOLE_W-1:0] whole,
  input  logic [FRAC_W-1:0]           frac,
  input  logic [gfp_pkg::LEN_W-1:0]   len,
  output logic [gfp_pkg::MAG_W-1:0]   mag
);
  import gfp_pkg::*;

  localparam int DEG_PROD_W = WHOLE_W + DEG_RECIP_W;
  localparam int MIN_PROD_W = 28 + MIN_RECIP_W;

  logic [DEG_PROD_W-1:0] deg_prod;
  logic [FRAC_W+23:0]    frac_prod;
  logic [WHOLE_W-1:0]    deg_x100, min_full;
  logic [29:0]           scaled;
  logic [MIN_PROD_W-1:0] min_prod;
  logic [34:0]           units;

  logic [DEG_W-1:0]   deg_s1_r, deg_s2_r, deg_s3_r;
  logic [WHOLE_W-1:0] whole_s1_r;
  logic [23:0]        fracm_s1_r, fracm_s2_r;
  logic [6:0]         min_s2_r;
  logic [27:0]        quarter_s3_r;
  logic [24:0]        minpart_s4_r;
  logic [33:0]        degu_s4_r;
  logic [MAG_W-1:0]   mag_s5_r;

  // Stage 1: degrees by reciprocal of 100; fraction scaled to seven digits.
  assign deg_prod  = {{DEG_RECIP_W{1'b0}}, whole} * {{WHOLE_W{1'b0}}, DEG_RECIP};
  assign frac_prod = {24'd0, frac} * {{FRAC_W{1'b0}}, pow10_tab(3'd7 - len)};

  // Stage 2: whole minutes left over after the degrees.
  assign deg_x100 = {6'd0, deg_s1_r} * 17'd100;
  assign min_full = whole_s1_r - deg_x100;

  // Stage 3: minutes in 1e-7 minute units; the quarter is the first step of / 60.
  assign scaled = {23'd0, min_s2_r} * 30'd10000000 + {6'd0, fracm_s2_r};

  // Stage 4: divide the quarter by 15 through its reciprocal.
  assign min_prod = {{MIN_RECIP_W{1'b0}}, quarter_s3_r} * {28'd0, MIN_RECIP};

  // Stage 5: add degrees and minutes, then clamp.
  assign units = {1'b0, degu_s4_r} + {10'd0, minpart_s4_r};

  always_ff @(posedge clk) begin
    if (en) begin
      deg_s1_r     <= deg_prod[DEG_SHIFT+DEG_W-1:DEG_SHIFT];
      whole_s1_r   <= whole;
      fracm_s1_r   <= frac_prod[23:0];
      deg_s2_r     <= deg_s1_r;
      min_s2_r     <= min_full[6:0];
      fracm_s2_r   <= fracm_s1_r;
      deg_s3_r     <= deg_s2_r;
      quarter_s3_r <= scaled[29:2];
      minpart_s4_r <= min_prod[MIN_SHIFT+24:MIN_SHIFT];
      degu_s4_r    <= {23'd0, deg_s3_r} * 34'd10000000;
      mag_s5_r     <= (units > {4'd0, LIMIT}) ? LIMIT : units[MAG_W-1:0];
    end
  end

  assign mag = mag_s5_r;

endmodule

// ----- src/gfp_back.sv -----
// Back end: drains the queue, converts both coordinates and holds the result word.
`timescale 1ns / 1ps

module gfp_back #(
  parameter int  FRACTION_DIGITS = gfp_pkg::FRACTION_DIGITS_DEF,
  localparam int FRAC_W = gfp_pkg::frac_width(FRACTION_DIGITS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_valid,
  output logic                        rd_ready,
  input  gfp_pkg::frame_info_t        rd_info,
  input  logic [gfp_pkg::WHOLE_W-1:0] rd_lat_whole,
  input  logic [FRAC_W-1:0]           rd_lat_frac,
  input  logic [gfp_pkg::LEN_W-1:0]   rd_lat_len,
  input  logic [gfp_pkg::WHOLE_W-1:0] rd_lon_whole,
  input  logic [FRAC_W-1:0]           rd_lon_frac,
  input  logic [gfp_pkg::LEN_W-1:0]   rd_lon_len,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gfp_pkg::status_t            out_status,
  output logic signed [30:0]          out_latitude,
  output logic signed [31:0]          out_longitude,
  output logic [7:0]                  out_satellites
);
  import gfp_pkg::*;

  localparam int STAGES = 5;

  logic             en;
  logic [STAGES-1:0] vld_r;
  frame_info_t      info_r [STAGES];
  logic [MAG_W-1:0] lat_mag, lon_mag;
  logic [30:0]      lat_nxt;
  logic [31:0]      lon_nxt;
  logic             out_valid_r;
  frame_info_t      out_info_r;
  logic [30:0]      out_lat_r;
  logic [31:0]      out_lon_r;

  // The whole pipeline moves whenever the output word is free or being taken.
  assign en       = !out_valid_r || out_ready;
  assign rd_ready = en;

  gfp_conv #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .LIMIT           (LAT_LIMIT)
  ) u_lat_conv (
    .clk   (clk),
    .en    (en),
    .whole (rd_lat_whole),
    .frac  (rd_lat_frac),
    .len   (rd_lat_len),
    .mag   (lat_mag)
  );

  gfp_conv #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .LIMIT           (LON_LIMIT)
  ) u_lon_conv (
    .clk   (clk),
    .en    (en),
    .whole (rd_lon_whole),
    .frac  (rd_lon_frac),
    .len   (rd_lon_len),
    .mag   (lon_mag)
  );

  // Valid flags alongside the converter stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[STAGES-2:0], rd_valid};
      out_valid_r <= vld_r[STAGES-1];
    end
  end

  // Sentence control travelling with the coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      info_r[0] <= rd_info;
      for (int i = 1; i < STAGES; i++) begin
        info_r[i] <= info_r[i-1];
      end
    end
  end

  // Sign and rejection applied on the way into the output word.
  always_comb begin
    lat_nxt = '0;
    lon_nxt = '0;
    if (info_r[STAGES-1].status == STATUS_OK) begin
      lat_nxt = info_r[STAGES-1].negate ? (31'd0 - lat_mag) : lat_mag;
      lon_nxt = info_r[STAGES-1].negate ? (32'd0 - {1'b0, lon_mag}) : {1'b0, lon_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_info_r <= info_r[STAGES-1];
      out_lat_r  <= lat_nxt;
      out_lon_r  <= lon_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_info_r.status;
  assign out_latitude   = out_lat_r;
  assign out_longitude  = out_lon_r;
  assign out_satellites = out_info_r.satellites;

endmodule

// ----- src/gps_fix_field_parser.sv -----
// Each finished sentence passes the result queue, the converter and the output register.
// Throughput: one byte per cycle while in_ready is high; the result queue and a 5-stage
// converter pipeline let sentences end on consecutive bytes, limited only by out_ready.
// in_ready falls whenever the result queue is full, which only follows a held output word.
// Reset (rst_n low, synchronous) clears parse state, queue and valid flags and loads
// the register defaults: 8 commas, 4 satellites, coordinates negated.
`timescale 1ns / 1ps

module gps_fix_field_parser #(
  parameter int FRACTION_DIGITS = gfp_pkg::FRACTION_DIGITS_DEF,
  parameter int QUEUE_DEPTH     = gfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte_in,
  input  logic                          in_frame_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic signed [30:0]            out_latitude,
  output logic signed [31:0]            out_longitude,
  output logic [7:0]                    out_satellites,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import gfp_pkg::*;

  localparam int FRAC_W = frac_width(FRACTION_DIGITS);
  localparam int WORD_W = $bits(frame_info_t) + 2 * (WHOLE_W + FRAC_W + LEN_W);

  cfg_t               cfg_r;
  logic               push_ready, push_valid;
  frame_info_t        push_info, rd_info;
  logic [WHOLE_W-1:0] push_lat_whole, push_lon_whole, rd_lat_whole, rd_lon_whole;
  logic [FRAC_W-1:0]  push_lat_frac, push_lon_frac, rd_lat_frac, rd_lon_frac;
  logic [LEN_W-1:0]   push_lat_len, push_lon_len, rd_lat_len, rd_lon_len;
  logic [WORD_W-1:0]  wr_word, rd_word;
  logic               rd_valid, rd_ready;
  status_t            status;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.required_commas <= 8'd8;
      cfg_r.min_satellites  <= 8'd4;
      cfg_r.negate          <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REQUIRED_COMMAS: cfg_r.required_commas <= cfg_data;
        REG_MIN_SATELLITES:  cfg_r.min_satellites  <= cfg_data;
        REG_NEGATE:          cfg_r.negate          <= cfg_data[0];
        default:             ;
      endcase
    end
  end

  gfp_front #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .in_frame_end   (in_frame_end),
    .cfg            (cfg_r),
    .push_ready     (push_ready),
    .push_valid     (push_valid),
    .push_info      (push_info),
    .push_lat_whole (push_lat_whole),
    .push_lat_frac  (push_lat_frac),
    .push_lat_len   (push_lat_len),
    .push_lon_whole (push_lon_whole),
    .push_lon_frac  (push_lon_frac),
    .push_lon_len   (push_lon_len)
  );

  // Sentence record packed into one queue word.
  assign wr_word = {push_info, push_lat_whole, push_lat_frac, push_lat_len,
                    push_lon_whole, push_lon_frac, push_lon_len};
  assign {rd_info, rd_lat_whole, rd_lat_frac, rd_lat_len,
          rd_lon_whole, rd_lon_frac, rd_lon_len} = rd_word;

  gfp_fifo #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (wr_word),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_word)
  );

  gfp_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rd_valid       (rd_valid),
    .rd_ready       (rd_ready),
    .rd_info        (rd_info),
    .rd_lat_whole   (rd_lat_whole),
    .rd_lat_frac    (rd_lat_frac),
    .rd_lat_len     (rd_lat_len),
    .rd_lon_whole   (rd_lon_whole),
    .rd_lon_frac    (rd_lon_frac),
    .rd_lon_len     (rd_lon_len),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (status),
    .out_latitude   (out_latitude),
    .out_longitude  (out_longitude),
    .out_satellites (out_satellites)
  );

  assign out_status = status;

endmodule

// ----- src/gfp_checker.sv -----
// Port-level checks on the result channel of the parser, bound to the top level.
`timescale 1ns / 1ps

module gfp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic signed [30:0] out_latitude,
  input logic signed [31:0] out_longitude,
  input logic [7:0]        out_satellites
);
  import gfp_pkg::*;

  // A held result word keeps its contents until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_latitude)
      && $stable(out_longitude) && $stable(out_satellites))
    else $error("result word changed while stalled");

  // A rejected sentence carries no position.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_latitude == 31'sd0 && out_longitude == 32'sd0)
    else $error("rejected sentence with nonzero position");

  // Latitude stays within its clamp.
  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_latitude <= 31'sd900000000 && out_latitude >= -31'sd900000000)
    else $error("latitude out of range");

  // Longitude stays within its clamp.
  a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_longitude <= 32'sd1800000000 && out_longitude >= -32'sd1800000000)
    else $error("longitude out of range");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind gps_fix_field_parser gfp_checker u_gfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_latitude   (out_latitude),
  .out_longitude  (out_longitude),
  .out_satellites (out_satellites)
);
